// ----- sv/bez_pkg.sv -----
`timescale 1ns / 1ps
// Shared register map constants for the cubic Bezier point evaluator.
package bez_pkg;

   localparam int CSR_IDX_BITS = 3;
   localparam int NUM_POINTS   = 4;

   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_P0_X = csr_index_type'(0);
   localparam csr_index_type REG_P0_Y = csr_index_type'(1);
   localparam csr_index_type REG_P1_X = csr_index_type'(2);
   localparam csr_index_type REG_P1_Y = csr_index_type'(3);
   localparam csr_index_type REG_P2_X = csr_index_type'(4);
   localparam csr_index_type REG_P2_Y = csr_index_type'(5);
   localparam csr_index_type REG_P3_X = csr_index_type'(6);
   localparam csr_index_type REG_P3_Y = csr_index_type'(7);

endpackage

// ----- sv/bez_level.sv -----
`timescale 1ns / 1ps
// One de Casteljau level: exact lerps a*2^F + t*(b - a) over a three-stage pipeline.
module bez_level #(
   parameter int F       = 16,
   parameter int IN_BITS = 16,
   parameter int N_OUT   = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [F:0]                       in_t,
   input  logic signed [IN_BITS-1:0]        in_x [N_OUT+1],
   input  logic signed [IN_BITS-1:0]        in_y [N_OUT+1],
   output logic                             out_valid,
   output logic [F:0]                       out_t,
   output logic signed [IN_BITS+F-1:0]      out_x [N_OUT],
   output logic signed [IN_BITS+F-1:0]      out_y [N_OUT]
);

   localparam int OUT_BITS = IN_BITS + F;
   localparam int D_BITS   = IN_BITS + 1;
   localparam int LO_BITS  = (D_BITS + 1) / 2;
   localparam int HI_BITS  = D_BITS - LO_BITS;
   localparam int PL_BITS  = F + 1 + LO_BITS;
   localparam int PH_BITS  = F + 2 + HI_BITS;

   logic signed [IN_BITS-1:0] pt [2][N_OUT+1];

   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [F:0]       s1_t_ff, s2_t_ff, s3_t_ff;

   assign pt[0] = in_x;
   assign pt[1] = in_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_t_ff <= in_t;
      s2_t_ff <= s1_t_ff;
      s3_t_ff <= s2_t_ff;
   end

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis
      for (genvar ln = 0; ln < N_OUT; ln++) begin : g_lane
         logic signed [IN_BITS-1:0] a_s1_ff, a_s2_ff;
         logic signed [D_BITS-1:0]  d_in, d_ff;
         logic [PL_BITS-1:0]        pl_in, pl_ff;
         logic signed [PH_BITS-1:0] ph_in, ph_ff;
         logic [OUT_BITS-1:0]       o_in, o_ff;

         assign d_in  = D_BITS'(pt[ax][ln+1]) - D_BITS'(pt[ax][ln]);
         assign pl_in = PL_BITS'(s1_t_ff) * PL_BITS'(d_ff[LO_BITS-1:0]);
         assign ph_in = PH_BITS'($signed({1'b0, s1_t_ff}))
                      * PH_BITS'($signed(d_ff[D_BITS-1:LO_BITS]));
         assign o_in  = (OUT_BITS'(a_s2_ff) << F)
                      + (OUT_BITS'(ph_ff) << LO_BITS)
                      + OUT_BITS'(pl_ff);

         always_ff @(posedge clock) begin
            a_s1_ff <= pt[ax][ln];
            d_ff    <= d_in;
            a_s2_ff <= a_s1_ff;
            pl_ff   <= pl_in;
            ph_ff   <= ph_in;
            o_ff    <= o_in;
         end

         if (ax == 0) begin : g_x
            assign out_x[ln] = $signed(o_ff);
         end else begin : g_y
            assign out_y[ln] = $signed(o_ff);
         end
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_t     = s3_t_ff;

endmodule

// ----- sv/bez_trunc.sv -----
`timescale 1ns / 1ps
// Output stage: drop the 3F fraction bits, rounding toward zero, and register the word.
module bez_trunc #(
   parameter int F = 16,
   parameter int C = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [C+3*F-1:0] num_x,
   input  logic signed [C+3*F-1:0] num_y,
   output logic                  rsp_strobe,
   output logic signed [C-1:0]   rsp_point_x,
   output logic signed [C-1:0]   rsp_point_y
);

   localparam int K  = 3 * F;
   localparam int NW = C + K;
   localparam logic [NW-1:0] LOW_MASK = {{C{1'b0}}, {K{1'b1}}};

   logic [NW-1:0]  sum_x, sum_y;
   logic           strobe_ff;
   logic [C-1:0]   x_in, y_in, x_ff, y_ff;

   assign sum_x = num_x + (num_x[NW-1] ? LOW_MASK : '0);
   assign sum_y = num_y + (num_y[NW-1] ? LOW_MASK : '0);
   assign x_in  = sum_x[K +: C];
   assign y_in  = sum_y[K +: C];

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_point_x = $signed(x_ff);
   assign rsp_point_y = $signed(y_ff);

endmodule

// ----- sv/cubic_bezier_point_eval.sv -----
`timescale 1ns / 1ps
// Top level of the cubic Bezier point evaluator.
//
// Load the four control points through the csr_ port: csr_we high writes csr_wdata into
// register csr_index (p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y) at that clock edge.
// Write them only while no word is in flight.
// Issue a parameter t (16 fraction bits, 65536 = 1.0, larger values act as 1.0) by raising
// start with req_param_t; the word is taken at any edge where start is high and busy is low.
// busy is high only during reset, so one word can be taken every cycle while start is high.
// The point comes back on rsp_point_x / rsp_point_y with rsp_strobe high for one cycle,
// in issue order; there is no back-pressure.
// The path runs through an input register, three de Casteljau levels of three stages each
// (difference, split partial products, sum), and the rounding output register.
// Reset clears all control points to zero and drops every word in flight.
module cubic_bezier_point_eval
   import bez_pkg::*;
#(
   parameter int T_FRAC_BITS = 16,
   parameter int COORD_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [T_FRAC_BITS:0]          req_param_t,
   input  logic                          csr_we,
   input  csr_index_type                 csr_index,
   input  logic [COORD_BITS-1:0]         csr_wdata,
   output logic                          rsp_strobe,
   output logic signed [COORD_BITS-1:0]  rsp_point_x,
   output logic signed [COORD_BITS-1:0]  rsp_point_y
);

   localparam int F        = T_FRAC_BITS;
   localparam int C        = COORD_BITS;
   localparam int PIPE_LAT = 11;
   localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

   logic signed [C-1:0] cfg_ff [NUM_POINTS*2];

   logic                accept;
   logic                in_valid_ff;
   logic [F:0]          t_in, t_ff;

   logic signed [C-1:0]       l0_x [NUM_POINTS];
   logic signed [C-1:0]       l0_y [NUM_POINTS];
   logic                      l1_valid, l2_valid, l3_valid;
   logic [F:0]                l1_t, l2_t, l3_t;
   logic signed [C+F-1:0]     l1_x [NUM_POINTS-1];
   logic signed [C+F-1:0]     l1_y [NUM_POINTS-1];
   logic signed [C+2*F-1:0]   l2_x [NUM_POINTS-2];
   logic signed [C+2*F-1:0]   l2_y [NUM_POINTS-2];
   logic signed [C+3*F-1:0]   l3_x [NUM_POINTS-3];
   logic signed [C+3*F-1:0]   l3_y [NUM_POINTS-3];

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POINTS*2; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= $signed(csr_wdata);
      end
   end

   // saturate t above one
   assign t_in = (req_param_t > T_ONE) ? T_ONE : req_param_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
   end

   assign l0_x[0] = cfg_ff[REG_P0_X];
   assign l0_x[1] = cfg_ff[REG_P1_X];
   assign l0_x[2] = cfg_ff[REG_P2_X];
   assign l0_x[3] = cfg_ff[REG_P3_X];
   assign l0_y[0] = cfg_ff[REG_P0_Y];
   assign l0_y[1] = cfg_ff[REG_P1_Y];
   assign l0_y[2] = cfg_ff[REG_P2_Y];
   assign l0_y[3] = cfg_ff[REG_P3_Y];

   bez_level #(.F(F), .IN_BITS(C), .N_OUT(NUM_POINTS-1)) u_level1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_t      (t_ff),
      .in_x      (l0_x),
      .in_y      (l0_y),
      .out_valid (l1_valid),
      .out_t     (l1_t),
      .out_x     (l1_x),
      .out_y     (l1_y)
   );

   bez_level #(.F(F), .IN_BITS(C+F), .N_OUT(NUM_POINTS-2)) u_level2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l1_valid),
      .in_t      (l1_t),
      .in_x      (l1_x),
      .in_y      (l1_y),
      .out_valid (l2_valid),
      .out_t     (l2_t),
      .out_x     (l2_x),
      .out_y     (l2_y)
   );

   bez_level #(.F(F), .IN_BITS(C+2*F), .N_OUT(NUM_POINTS-3)) u_level3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l2_valid),
      .in_t      (l2_t),
      .in_x      (l2_x),
      .in_y      (l2_y),
      .out_valid (l3_valid),
      .out_t     (l3_t),
      .out_x     (l3_x),
      .out_y     (l3_y)
   );

   bez_trunc #(.F(F), .C(C)) u_trunc (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (l3_valid),
      .num_x       (l3_x[0]),
      .num_y       (l3_y[0]),
      .rsp_strobe  (rsp_strobe),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y)
   );

   a_word_returns: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_strobe)
      else $error("accepted word did not return on time");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_LAT))
      else $error("result strobe without an accepted word");

   a_start_point: assert property (@(posedge clock) disable iff (reset)
      (l3_valid && l3_t == '0) |=>
         (rsp_point_x == cfg_ff[REG_P0_X] && rsp_point_y == cfg_ff[REG_P0_Y]))
      else $error("t of zero did not give the first control point");

   a_end_point: assert property (@(posedge clock) disable iff (reset)
      (l3_valid && l3_t == T_ONE) |=>
         (rsp_point_x == cfg_ff[REG_P3_X] && rsp_point_y == cfg_ff[REG_P3_Y]))
      else $error("t of one did not give the last control point");

endmodule

// ----- bench/bezier_point_checker.sv -----
`timescale 1ns / 1ps
// Checker for the cubic Bezier point evaluator: mirrors control points, predicts and compares.
module bezier_point_checker
   import bez_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [16:0]         req_param_t,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                rsp_strobe,
   input  logic signed [15:0]  rsp_point_x,
   input  logic signed [15:0]  rsp_point_y,
   output int                  fail_count,
   output int                  pending,
   output int                  points_checked
);

   localparam logic [16:0] T_ONE = 17'd65536;

   typedef struct {
      logic [16:0]        param_t;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } curve_point_type;

   logic signed [15:0] ctrl_x [NUM_POINTS];
   logic signed [15:0] ctrl_y [NUM_POINTS];
   curve_point_type    point_q [$];

   function automatic logic signed [15:0] bernstein_axis(input logic [16:0] param_t,
                                                         input logic signed [15:0] c0,
                                                         input logic signed [15:0] c1,
                                                         input logic signed [15:0] c2,
                                                         input logic signed [15:0] c3);
      logic [16:0]        t_sat;
      logic signed [79:0] tw, sw, w0, w1, w2, w3, acc, mag;
      logic [15:0]        q;
      logic               neg;
      t_sat = (param_t > T_ONE) ? T_ONE : param_t;
      tw = {63'd0, t_sat};
      sw = {63'd0, T_ONE - t_sat};
      w0 = c0;
      w1 = c1;
      w2 = c2;
      w3 = c3;
      acc = sw * sw * sw * w0 + 80'sd3 * sw * sw * tw * w1
          + 80'sd3 * sw * tw * tw * w2 + tw * tw * tw * w3;
      neg = acc < 0;
      mag = neg ? -acc : acc;
      q = mag[63:48];
      return neg ? -q : q;
   endfunction

   always @(posedge clock) begin
      curve_point_type want;
      curve_point_type fresh;
      if (reset) begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            ctrl_x[i] = '0;
            ctrl_y[i] = '0;
         end
         point_q.delete();
         fail_count = 0;
         points_checked = 0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_P0_X: ctrl_x[0] = csr_wdata;
               REG_P0_Y: ctrl_y[0] = csr_wdata;
               REG_P1_X: ctrl_x[1] = csr_wdata;
               REG_P1_Y: ctrl_y[1] = csr_wdata;
               REG_P2_X: ctrl_x[2] = csr_wdata;
               REG_P2_Y: ctrl_y[2] = csr_wdata;
               REG_P3_X: ctrl_x[3] = csr_wdata;
               REG_P3_Y: ctrl_y[3] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            points_checked++;
            if (point_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected point x=%0d y=%0d", $time, rsp_point_x, rsp_point_y);
            end else begin
               want = point_q.pop_front();
               if (rsp_point_x !== want.x) begin
                  fail_count++;
                  $display("%0t: point_x mismatch t=%0d expected %0d actual %0d",
                           $time, want.param_t, want.x, rsp_point_x);
               end
               if (rsp_point_y !== want.y) begin
                  fail_count++;
                  $display("%0t: point_y mismatch t=%0d expected %0d actual %0d",
                           $time, want.param_t, want.y, rsp_point_y);
               end
            end
         end
         if (start && !busy) begin
            fresh.param_t = req_param_t;
            fresh.x = bernstein_axis(req_param_t, ctrl_x[0], ctrl_x[1], ctrl_x[2], ctrl_x[3]);
            fresh.y = bernstein_axis(req_param_t, ctrl_y[0], ctrl_y[1], ctrl_y[2], ctrl_y[3]);
            point_q.push_back(fresh);
         end
      end
      pending = point_q.size();
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the cubic Bezier point evaluator: stimulus, watchdog and verdict.
module tb
   import bez_pkg::*;
();

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          WORDS_PER_SET  = 50;
   localparam logic [16:0] T_ONE          = 17'd65536;
   localparam logic [16:0] T_MAX          = 17'h1ffff;

   localparam csr_index_type REG_ORDER [8] = '{REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y,
                                               REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y};

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [16:0]         req_param_t;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [15:0]         csr_wdata;
   logic                rsp_strobe;
   logic signed [15:0]  rsp_point_x;
   logic signed [15:0]  rsp_point_y;
   int                  fail_count;
   int                  pending;
   int                  points_checked;

   logic [15:0]         point_set [8];
   int                  sender_idle_pct;
   int                  words_sent;
   int                  point_sets;
   int                  stall_cycles;

   cubic_bezier_point_eval #(
      .T_FRAC_BITS (16),
      .COORD_BITS  (16)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_param_t (req_param_t),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_strobe  (rsp_strobe),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y)
   );

   bezier_point_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_param_t    (req_param_t),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .fail_count     (fail_count),
      .pending        (pending),
      .points_checked (points_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [16:0] random_param_t();
      case ($urandom_range(9))
         0: return T_ONE;
         1: return 17'd0;
         2: return 17'($urandom_range(T_MAX, T_ONE + 1));
         default: return 17'($urandom_range(T_ONE));
      endcase
   endfunction

   function automatic logic [15:0] random_coord();
      case ($urandom_range(5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   // drop start and hold until every point is back
   task automatic settle();
      start <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_points();
      settle();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= REG_ORDER[i];
         csr_wdata <= point_set[REG_ORDER[i]];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      point_sets++;
   endtask

   task automatic send_word(input logic [16:0] param_t);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_param_t <= param_t;
      do
         @(posedge clock);
      while (busy);
      @(negedge clock);
      words_sent++;
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_param_t     = '0;
      csr_we          = 1'b0;
      csr_index       = REG_P0_X;
      csr_wdata       = '0;
      sender_idle_pct = 21;
      words_sent      = 0;
      point_sets      = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(17'd0);
      send_word(T_ONE);

      for (int i = 0; i < 8; i++)
         point_set[REG_ORDER[i]] = (i % 2 == 0) ? 16'h7fff : 16'h8000;
      load_points();
      send_word(17'd0);
      send_word(17'd1);
      send_word(T_ONE);
      send_word(T_MAX);

      for (int i = 0; i < 8; i++)
         point_set[REG_ORDER[i]] = ((i / 2 + i) % 2 == 0) ? 16'h8000 : 16'h7fff;
      load_points();
      send_word(17'd0);
      send_word(17'd1);
      send_word(17'd32768);
      send_word(17'd65535);
      send_word(T_ONE);
      send_word(T_ONE + 17'd1);
      send_word(17'h15555);
      send_word(T_MAX);

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 46 : 0;
         for (int set = 0; set < 3; set++) begin
            for (int i = 0; i < 8; i++)
               point_set[REG_ORDER[i]] = random_coord();
            load_points();
            repeat (WORDS_PER_SET) send_word(random_param_t());
         end
      end

      settle();
      $display("Checked %0d curve points from %0d parameter words over %0d control point sets",
               points_checked, words_sent, point_sets);
      $display("t ranged from 0 past 1.0 with the sender idling 21, 46 and 0 percent of cycles");
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/bez_pkg.sv
sv/bez_level.sv
sv/bez_trunc.sv
sv/cubic_bezier_point_eval.sv
bench/bezier_point_checker.sv
bench/tb.sv
